### design/mcfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcfe_pkg
// Shared constants and register codes of the motor command frame encoder.
// ----------------------------------------------------------------------------
package mcfe_pkg;

  localparam int unsigned POS_BITS   = 16;
  localparam int unsigned GAIN_BITS  = 12;
  localparam int unsigned DIV_STAGES = 16;
  localparam int unsigned SPAN_W     = 32;
  localparam int unsigned NUM_W      = SPAN_W + DIV_STAGES;

  typedef enum logic [2:0] {
    REG_POS_LIMIT    = 3'd0,
    REG_VEL_LIMIT    = 3'd1,
    REG_TORQUE_LIMIT = 3'd2,
    REG_STIFF_MIN    = 3'd3,
    REG_STIFF_MAX    = 3'd4,
    REG_DAMP_MIN     = 3'd5,
    REG_DAMP_MAX     = 3'd6,
    REG_AXIS_REV     = 3'd7
  } reg_idx_e;

endpackage
`default_nettype wire

### design/mcfe_div_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcfe_div_lane
// Restoring divider pipe: up to one quotient bit per stage, stalls on en_i.
// ----------------------------------------------------------------------------
module mcfe_div_lane #(
  parameter int unsigned BITS  = mcfe_pkg::POS_BITS,
  parameter int unsigned DEPTH = mcfe_pkg::DIV_STAGES
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [mcfe_pkg::SPAN_W+DEPTH-1:0] num_i,
  input  wire logic [mcfe_pkg::SPAN_W-1:0]  span_i,
  output logic      [BITS-1:0]              code_o
);

  localparam int unsigned W = mcfe_pkg::SPAN_W + DEPTH;

  logic [W-1:0]                  rem_q  [DEPTH];
  logic [mcfe_pkg::SPAN_W-1:0]   span_q [DEPTH];
  logic [BITS-1:0]               quo_q  [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    localparam int unsigned J = DEPTH - 1 - k;
    logic [W-1:0]                rem_in;
    logic [mcfe_pkg::SPAN_W-1:0] span_in;
    logic [BITS-1:0]             quo_in;
    logic [W-1:0]                rem_d;
    logic [BITS-1:0]             quo_d;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign span_in = span_i;
      assign quo_in  = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign span_in = span_q[k-1];
      assign quo_in  = quo_q[k-1];
    end

    if (J < BITS) begin : g_bit
      logic [W-1:0] sub;
      assign sub = {{DEPTH{1'b0}}, span_in} << J;
      always_comb begin
        rem_d = rem_in;
        quo_d = quo_in;
        if (rem_in >= sub) begin
          rem_d    = rem_in - sub;
          quo_d[J] = 1'b1;
        end
      end
    end else begin : g_pass
      assign rem_d = rem_in;
      assign quo_d = quo_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        span_q[k] <= span_in;
        quo_q[k]  <= quo_d;
      end
    end
  end

  assign code_o = quo_q[DEPTH-1];

endmodule
`default_nettype wire

### design/motor_command_frame_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// motor_command_frame_encoder
// Packs one motor command into an 8-byte mini-cheetah style CAN frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per beat: five signed Q16.16 values.
//   m_axis returns one 64-bit frame per command, byte 0 in bits 63:56.
//   cfg writes limit registers by index; cfg_ready_o is always high. Write
//   only while no command is in flight.
// Pipeline: an accepted input beat passes the sign/negate stage, the clamp
//   and scale stage and 16 divider stages before it is a valid output beat;
//   the 16-bit position divide sets the depth, the 12-bit lanes pad to it.
// Throughput: one command per cycle while the output does not stall; each
//   divider stage that resolves a quotient bit uses one 48-bit compare and subtract.
// Reset: valid bits clear, registers return to their default limits.
// Stall: while m_axis_tvalid is high and m_axis_tready is low the whole
//   pipeline holds and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module motor_command_frame_encoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_target[31:0], vel_target[63:32], torque_ff[95:64],
  // stiffness[127:96], damping[159:128]
  input  wire logic [159:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // frame_out[63:0]
  output logic      [63:0]  m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  localparam int unsigned DEPTH = mcfe_pkg::DIV_STAGES;
  localparam int unsigned NW    = mcfe_pkg::NUM_W;
  localparam int unsigned SW    = mcfe_pkg::SPAN_W;
  localparam int unsigned NV    = DEPTH + 2;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [SW-1:0] span;
  } lane_t;

  // Clamp x to [lo, hi], then form (x-lo)*(2^bits-1) and the span.
  // An empty range gives a zero numerator so the code comes out zero.
  function automatic lane_t prep(input logic signed [32:0] x,
                                 input logic signed [32:0] lo,
                                 input logic signed [32:0] hi,
                                 input int unsigned bits);
    logic signed [32:0] xc;
    logic signed [33:0] diff;
    logic signed [33:0] spn;
    logic [NW-1:0]      d;
    lane_t              r;
    xc   = x;
    if (xc < lo) xc = lo;
    if (xc > hi) xc = hi;
    diff = 34'(xc) - 34'(lo);
    spn  = 34'(hi) - 34'(lo);
    d    = {{(NW-SW){1'b0}}, diff[SW-1:0]};
    if (hi <= lo) begin
      r.num  = '0;
      r.span = {{(SW-1){1'b0}}, 1'b1};
    end else begin
      r.num  = (d << bits) - d;
      r.span = spn[SW-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [30:0] pos_lim_q, vel_lim_q, trq_lim_q;
  logic [30:0] kp_min_q, kp_max_q, kd_min_q, kd_max_q;
  logic        rev_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_lim_q <= 31'd819200;
      vel_lim_q <= 31'd3276800;
      trq_lim_q <= 31'd1179648;
      kp_min_q  <= 31'd0;
      kp_max_q  <= 31'd32768000;
      kd_min_q  <= 31'd0;
      kd_max_q  <= 31'd327680;
      rev_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (mcfe_pkg::reg_idx_e'(cfg_index_i))
        mcfe_pkg::REG_POS_LIMIT:    pos_lim_q <= cfg_data_i[30:0];
        mcfe_pkg::REG_VEL_LIMIT:    vel_lim_q <= cfg_data_i[30:0];
        mcfe_pkg::REG_TORQUE_LIMIT: trq_lim_q <= cfg_data_i[30:0];
        mcfe_pkg::REG_STIFF_MIN:    kp_min_q  <= cfg_data_i[30:0];
        mcfe_pkg::REG_STIFF_MAX:    kp_max_q  <= cfg_data_i[30:0];
        mcfe_pkg::REG_DAMP_MIN:     kd_min_q  <= cfg_data_i[30:0];
        mcfe_pkg::REG_DAMP_MAX:     kd_max_q  <= cfg_data_i[30:0];
        mcfe_pkg::REG_AXIS_REV:     rev_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves whenever the output slot frees up.
  logic en;
  logic [NV-1:0] v_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NV-2:0], s_axis_tvalid};
    end
  end

  // Stage A: sign-extend all five values and negate position, velocity and torque if the axis is reversed.
  logic signed [32:0] xa_d [5];
  logic signed [32:0] xa_q [5];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      xa_d[i] = 33'(signed'(s_axis_tdata[32*i +: 32]));
    end
    if (rev_q) begin
      for (int i = 0; i < 3; i++) begin
        xa_d[i] = -xa_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 5; i++) begin
        xa_q[i] <= xa_d[i];
      end
    end
  end

  // Stage B: clamp and scale each value into numerator and span.
  lane_t ln_d [5];
  lane_t ln_q [5];

  always_comb begin
    ln_d[0] = prep(xa_q[0], -$signed({2'b00, pos_lim_q}), $signed({2'b00, pos_lim_q}),
                   mcfe_pkg::POS_BITS);
    ln_d[1] = prep(xa_q[1], -$signed({2'b00, vel_lim_q}), $signed({2'b00, vel_lim_q}),
                   mcfe_pkg::GAIN_BITS);
    ln_d[2] = prep(xa_q[2], -$signed({2'b00, trq_lim_q}), $signed({2'b00, trq_lim_q}),
                   mcfe_pkg::GAIN_BITS);
    ln_d[3] = prep(xa_q[3], $signed({2'b00, kp_min_q}), $signed({2'b00, kp_max_q}),
                   mcfe_pkg::GAIN_BITS);
    ln_d[4] = prep(xa_q[4], $signed({2'b00, kd_min_q}), $signed({2'b00, kd_max_q}),
                   mcfe_pkg::GAIN_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 5; i++) begin
        ln_q[i] <= ln_d[i];
      end
    end
  end

  // Divider lanes: position, velocity, torque, stiffness, damping.
  logic [mcfe_pkg::POS_BITS-1:0]  pc;
  logic [mcfe_pkg::GAIN_BITS-1:0] vc, tc, kpc, kdc;

  mcfe_div_lane #(.BITS(mcfe_pkg::POS_BITS), .DEPTH(DEPTH)) u_pos (
    .clk_i(clk_i), .en_i(en), .num_i(ln_q[0].num), .span_i(ln_q[0].span), .code_o(pc));
  mcfe_div_lane #(.BITS(mcfe_pkg::GAIN_BITS), .DEPTH(DEPTH)) u_vel (
    .clk_i(clk_i), .en_i(en), .num_i(ln_q[1].num), .span_i(ln_q[1].span), .code_o(vc));
  mcfe_div_lane #(.BITS(mcfe_pkg::GAIN_BITS), .DEPTH(DEPTH)) u_trq (
    .clk_i(clk_i), .en_i(en), .num_i(ln_q[2].num), .span_i(ln_q[2].span), .code_o(tc));
  mcfe_div_lane #(.BITS(mcfe_pkg::GAIN_BITS), .DEPTH(DEPTH)) u_kp (
    .clk_i(clk_i), .en_i(en), .num_i(ln_q[3].num), .span_i(ln_q[3].span), .code_o(kpc));
  mcfe_div_lane #(.BITS(mcfe_pkg::GAIN_BITS), .DEPTH(DEPTH)) u_kd (
    .clk_i(clk_i), .en_i(en), .num_i(ln_q[4].num), .span_i(ln_q[4].span), .code_o(kdc));

  // Frame layout: pos | vel | stiffness | damping | torque.
  assign m_axis_tdata = {pc, vc, kpc, kdc, tc};

  // Assertions.
  a_ready_rule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output slot");

  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[0])
    else $error("accepted beat did not enter the pipeline");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(v_q) && $stable(m_axis_tdata)))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire

### bench/mcfe_frame_checker.sv
// ----------------------------------------------------------------------------
// mcfe_frame_checker
// Watches the command, frame and register channels, predicts each frame and
// compares it with the frame that comes out, oldest first.
// ----------------------------------------------------------------------------
module mcfe_frame_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [159:0] s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [63:0]  m_axis_tdata,
  input  wire logic         cfg_valid_i,
  input  wire logic         cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  logic [30:0] lim_pos, lim_vel, lim_trq, kp_lo, kp_hi, kd_lo, kd_hi;
  logic        rev;
  logic [63:0] frame_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = frame_q.size();

  function automatic logic [15:0] scale_code(longint x, longint lo, longint hi, int bits);
    longint unsigned full;
    longint unsigned span;
    longint unsigned d;
    full = (64'd1 << bits) - 1;
    if (hi <= lo) return 16'd0;
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    span = hi - lo;
    d    = x - lo;
    return 16'(((d * full) / span) & full);
  endfunction

  function automatic logic [63:0] encode_frame(logic [159:0] cmd);
    longint p, v, t, kp, kd;
    logic [15:0] pc, vc, tc, kpc, kdc;
    p  = longint'($signed(cmd[31:0]));
    v  = longint'($signed(cmd[63:32]));
    t  = longint'($signed(cmd[95:64]));
    kp = longint'($signed(cmd[127:96]));
    kd = longint'($signed(cmd[159:128]));
    if (rev) begin
      p = -p;
      v = -v;
      t = -t;
    end
    pc  = scale_code(p, -longint'(lim_pos), longint'(lim_pos), mcfe_pkg::POS_BITS);
    vc  = scale_code(v, -longint'(lim_vel), longint'(lim_vel), mcfe_pkg::GAIN_BITS);
    tc  = scale_code(t, -longint'(lim_trq), longint'(lim_trq), mcfe_pkg::GAIN_BITS);
    kpc = scale_code(kp, longint'(kp_lo), longint'(kp_hi), mcfe_pkg::GAIN_BITS);
    kdc = scale_code(kd, longint'(kd_lo), longint'(kd_hi), mcfe_pkg::GAIN_BITS);
    return {pc, vc[11:0], kpc[11:0], kdc[11:0], tc[11:0]};
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_pos <= 31'd819200;
      lim_vel <= 31'd3276800;
      lim_trq <= 31'd1179648;
      kp_lo   <= '0;
      kp_hi   <= 31'd32768000;
      kd_lo   <= '0;
      kd_hi   <= 31'd327680;
      rev     <= 1'b0;
      fails   = 0;
      frame_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_q.size() == 0) report_mismatch("unexpected frame", m_axis_tdata, '0);
        else begin
          logic [63:0] want;
          want = frame_q.pop_front();
          if (m_axis_tdata !== want) report_mismatch("frame_out", m_axis_tdata, want);
        end
      end
      if (s_axis_tvalid && s_axis_tready) frame_q.push_back(encode_frame(s_axis_tdata));
      if (cfg_valid_i && cfg_ready_o) begin
        case (mcfe_pkg::reg_idx_e'(cfg_index_i))
          mcfe_pkg::REG_POS_LIMIT:    lim_pos <= cfg_data_i[30:0];
          mcfe_pkg::REG_VEL_LIMIT:    lim_vel <= cfg_data_i[30:0];
          mcfe_pkg::REG_TORQUE_LIMIT: lim_trq <= cfg_data_i[30:0];
          mcfe_pkg::REG_STIFF_MIN:    kp_lo   <= cfg_data_i[30:0];
          mcfe_pkg::REG_STIFF_MAX:    kp_hi   <= cfg_data_i[30:0];
          mcfe_pkg::REG_DAMP_MIN:     kd_lo   <= cfg_data_i[30:0];
          mcfe_pkg::REG_DAMP_MAX:     kd_hi   <= cfg_data_i[30:0];
          mcfe_pkg::REG_AXIS_REV:     rev     <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end
endmodule

### bench/tb_motor_command_frame_encoder.sv
// ----------------------------------------------------------------------------
// tb_motor_command_frame_encoder
// Drives commands and register writes into the frame encoder under several
// idle/stall mixes; a checker beside the block predicts and compares frames.
// ----------------------------------------------------------------------------
module tb_motor_command_frame_encoder;

  localparam int LATENCY   = 18;
  localparam int MAX_CYCLE = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  int           fail_count;
  int           pending;
  int           cycle_cnt = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  motor_command_frame_encoder DUT (.*);

  mcfe_frame_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: end the run if something hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("tb_motor_command_frame_encoder NOT OK");
      $finish;
    end
  end

  // Receiver: stall at the percentage of the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Pick a value biased toward edges so clamps and range ends get hit.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      3: return 32'($urandom_range(40000000));
      4: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Send one command beat; hold tvalid until accepted. Drop tvalid only
  // on idle cycles so back-to-back beats keep it high.
  task automatic send_command(logic [159:0] cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(mcfe_pkg::reg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Drain the pipeline so register writes land while idle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic load_limits(logic [31:0] p, logic [31:0] v, logic [31:0] t,
                             logic [31:0] klo, logic [31:0] khi,
                             logic [31:0] dlo, logic [31:0] dhi, logic r);
    wait_drained();
    write_reg(mcfe_pkg::REG_POS_LIMIT, p);
    write_reg(mcfe_pkg::REG_VEL_LIMIT, v);
    write_reg(mcfe_pkg::REG_TORQUE_LIMIT, t);
    write_reg(mcfe_pkg::REG_STIFF_MIN, klo);
    write_reg(mcfe_pkg::REG_STIFF_MAX, khi);
    write_reg(mcfe_pkg::REG_DAMP_MIN, dlo);
    write_reg(mcfe_pkg::REG_DAMP_MAX, dhi);
    write_reg(mcfe_pkg::REG_AXIS_REV, {31'($urandom), r});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_commands(int n);
    repeat (n) send_command({pick_value(), pick_value(), pick_value(), pick_value(),
                             pick_value()});
  endtask

  initial begin
    logic [31:0] edges[6];
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h000C_8000,
              32'hFFF3_8000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes at reset limits, then reversed axis.
    foreach (edges[i]) send_command({5{edges[i]}});
    send_command({edges[0], edges[1], edges[4], edges[5], edges[2]});
    load_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF,
                32'h0, 32'h7FFF_FFFF, 1'b1);
    foreach (edges[i]) send_command({5{edges[i]}});
    // Empty ranges: zero position and velocity limits and gain max not above min; torque limit 1.
    load_limits(32'h8000_0000, 32'h0, 32'd1, 32'd500, 32'd500, 32'h7FFF_FFFE,
                32'd3, 1'b0);
    foreach (edges[i]) send_command({5{edges[i]}});
    send_command({32'd500, 32'd3, 32'd1, 32'hFFFF_FFFF, 32'd0});

    // Random: eight phases cycling through four idle/stall mixes, each with fresh limits.
    for (int ph = 0; ph < 8; ph++) begin
      load_limits(ph == 7 ? 32'd1 : $urandom, $urandom_range(1) ? 32'd3276800 : $urandom,
                  $urandom, $urandom_range(1) ? 32'd0 : $urandom_range(1000000),
                  $urandom, $urandom_range(65536), $urandom, 1'($urandom));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      random_commands(178);
    end

    recv_stall_pct = 0;
    wait_drained();
    if (fail_count == 0) begin
      $display("tb_motor_command_frame_encoder OK");
    end else begin
      $display("tb_motor_command_frame_encoder NOT OK");
    end
    $finish;
  end
endmodule
